@@ hdl/sfb_pkg.sv @@
`default_nettype none

package sfb_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE  = 8'h7e;
  localparam logic [7:0] ESC_BYTE   = 8'h7d;
  localparam logic [7:0] ESC_MASK   = 8'h20;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h40;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  // One classified payload byte, as handed from the front to the back
  typedef struct packed {
    logic       hdr;   // open a frame: send the header first
    logic [7:0] addr;  // address for the header
    logic       seq;   // sequence bit for the control byte
    logic [7:0] data;  // payload byte
    logic       trl;   // close the frame: send BCC2 and the closing flag
    logic [7:0] bcc;   // BCC2 including this byte
  } sfb_job_t;

  // True where a byte must go out escaped
  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  // Byte as it follows the escape, or as it is where no escape is needed
  function automatic logic [7:0] stuff_val(input logic [7:0] b);
    stuff_val = needs_esc(b) ? (b ^ ESC_MASK) : b;
  endfunction

  function automatic logic [7:0] ctrl_byte(input logic seq);
    ctrl_byte = seq ? CTRL_SEQ1 : CTRL_SEQ0;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sfb_front.sv @@
`default_nettype none

module sfb_front
  import sfb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       addr_we_i,
  input  wire logic [7:0] address_byte_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       first_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       sequence_bit_i,
  output sfb_job_t        job_o,
  output logic            job_push_o
);

  logic [7:0] addr_q;
  logic [7:0] acc_q, acc_d;
  logic       inside_q, inside_d;
  logic [7:0] bcc;

  // Classify the byte and fold it into the running check
  always_comb begin
    bcc        = first_byte_i ? payload_byte_i : (acc_q ^ payload_byte_i);
    job_push_o = accept_i && (first_byte_i || inside_q);
    acc_d      = acc_q;
    inside_d   = inside_q;
    if (job_push_o) begin
      acc_d    = last_byte_i ? 8'h00 : bcc;
      inside_d = !last_byte_i;
    end
    job_o.hdr  = first_byte_i;
    job_o.addr = addr_q;
    job_o.seq  = sequence_bit_i;
    job_o.data = payload_byte_i;
    job_o.trl  = last_byte_i;
    job_o.bcc  = bcc;
  end

  // Hold frame state and the address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= ADDR_RESET;
      acc_q    <= 8'h00;
      inside_q <= 1'b0;
    end else begin
      if (addr_we_i) begin
        addr_q <= address_byte_i;
      end
      acc_q    <= acc_d;
      inside_q <= inside_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sfb_queue.sv @@
`default_nettype none

module sfb_queue
  import sfb_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire sfb_job_t   data_i,
  input  wire logic       pop_i,
  output sfb_job_t        data_o,
  output logic            full_o,
  output logic            empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  sfb_job_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign level_o = cnt_q;

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/sfb_back.sv @@
`default_nettype none

module sfb_back
  import sfb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire sfb_job_t   head_i,
  input  wire logic       q_empty_i,
  output logic            q_pop_o,
  input  wire logic       pop_i,
  output logic            out_valid_o,
  output logic [7:0]      line_byte_o,
  output logic            run_last_o
);

  typedef enum logic [3:0] {
    ST_FLAG, ST_ADDR, ST_CTRL, ST_BCC1, ST_DESC, ST_DATA, ST_CESC, ST_CHK, ST_CLOSE
  } step_e;

  sfb_job_t   job_q, job_d, cur;
  step_e      step_q, step_d, step, nxt;
  logic       busy_q, busy_d;
  logic       valid_q, valid_d;
  logic [7:0] line_q, line_d, byte_v;
  logic       last_q, last_d;
  logic       done, fire;
  logic [7:0] ctrl;

  // Pick the job and step, then build one line byte
  always_comb begin
    cur  = busy_q ? job_q : head_i;
    ctrl = ctrl_byte(cur.seq);
    if (busy_q) begin
      step = step_q;
    end else if (cur.hdr) begin
      step = ST_FLAG;
    end else begin
      step = needs_esc(cur.data) ? ST_DESC : ST_DATA;
    end

    byte_v = FLAG_BYTE;
    nxt    = ST_FLAG;
    done   = 1'b0;
    unique case (step)
      ST_FLAG:  begin byte_v = FLAG_BYTE;  nxt = ST_ADDR; end
      ST_ADDR:  begin byte_v = cur.addr;   nxt = ST_CTRL; end
      ST_CTRL:  begin byte_v = ctrl;       nxt = ST_BCC1; end
      ST_BCC1:  begin
        byte_v = cur.addr ^ ctrl;
        nxt    = needs_esc(cur.data) ? ST_DESC : ST_DATA;
      end
      ST_DESC:  begin byte_v = ESC_BYTE;   nxt = ST_DATA; end
      ST_DATA:  begin
        byte_v = stuff_val(cur.data);
        nxt    = needs_esc(cur.bcc) ? ST_CESC : ST_CHK;
        done   = !cur.trl;
      end
      ST_CESC:  begin byte_v = ESC_BYTE;   nxt = ST_CHK; end
      ST_CHK:   begin byte_v = stuff_val(cur.bcc); nxt = ST_CLOSE; end
      ST_CLOSE: begin byte_v = FLAG_BYTE;  done = 1'b1; end
      default:  begin byte_v = FLAG_BYTE;  done = 1'b1; end
    endcase

    // Load the output register when there is a byte to send and the register is empty or being transferred out
    fire    = (busy_q || !q_empty_i) && (!valid_q || pop_i);
    q_pop_o = fire && !busy_q;

    busy_d  = busy_q;
    job_d   = job_q;
    step_d  = step_q;
    valid_d = valid_q && !pop_i;
    line_d  = line_q;
    last_d  = last_q;
    if (fire) begin
      busy_d  = !done;
      job_d   = cur;
      step_d  = nxt;
      valid_d = 1'b1;
      line_d  = byte_v;
      last_d  = done;
    end
  end

  // Hold sequencer state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      job_q   <= '0;
      step_q  <= ST_FLAG;
      valid_q <= 1'b0;
      line_q  <= 8'h00;
      last_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      job_q   <= job_d;
      step_q  <= step_d;
      valid_q <= valid_d;
      line_q  <= line_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign line_byte_o = line_q;
  assign run_last_o  = last_q;

endmodule

`default_nettype wire

@@ hdl/stuffed_info_frame_builder.sv @@
// Information frame builder with byte stuffing.
// Input side: present payload_byte_i with first_byte_i, last_byte_i and
// sequence_bit_i and raise push; the byte transfers at a clock edge where
// full is low. A byte with first_byte_i low outside an open frame is dropped.
// Output side: while empty is low, line_byte_o and run_last_o hold the oldest
// line byte; it transfers at a clock edge where pop is high. run_last_o marks
// the final line byte caused by one input byte.
// Each input byte yields 1 to 9 line bytes (header 4, stuffed byte 1-2,
// stuffed BCC2 1-2, closing flag 1). The output sequencer sends one line byte
// per cycle while the receiver keeps popping. The first line byte is
// registered in the queue and then in the output register. A queue of
// QUEUE_DEPTH classified bytes sits between the front end and the sequencer,
// so input keeps transferring while the sequencer or the receiver is busy.
// When the receiver stalls the output byte holds; the sequencer and then the
// queue fill and full rises. addr_we_i writes address_byte_i into the address
// register. Reset empties the queue and output, closes any frame, clears
// BCC2 and sets the address to 0x03.
`default_nettype none

module stuffed_info_frame_builder
  import sfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       addr_we_i,
  input  wire logic [7:0] address_byte_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       first_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       sequence_bit_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      line_byte_o,
  output logic            run_last_o
);

  sfb_job_t job_in, job_head;
  logic     q_push, q_pop, q_full, q_empty, out_valid;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

  assign full  = q_full;
  assign empty = !out_valid;

  sfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .addr_we_i      (addr_we_i),
    .address_byte_i (address_byte_i),
    .accept_i       (push && !q_full),
    .payload_byte_i (payload_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .sequence_bit_i (sequence_bit_i),
    .job_o          (job_in),
    .job_push_o     (q_push)
  );

  sfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .data_o  (job_head),
    .full_o  (q_full),
    .empty_o (q_empty),
    .level_o (q_level)
  );

  sfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (job_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .line_byte_o (line_byte_o),
    .run_last_o  (run_last_o)
  );

  // Never write into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue written while full");

  // Never take from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue read while empty");

  // Fill count rises on a push without a pop
  a_level_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_level == $past(q_level) + 1'b1))
    else $error("queue level lost a push");

endmodule

`default_nettype wire
